### sv/i2cram_pkg.sv
// Shared types and constants of the I2C register access master.
`timescale 1ns / 1ps

package i2cram_pkg;

    // Request opcodes as they arrive on the op port
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Bits in one bus byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Depth of each request and result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request class decided by the front end
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ
    } t_kind;

    // Error codes reported at the end of a transaction
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_START     = 3'd1,
        ERR_NACK_ADDR = 3'd2,
        ERR_NACK_REG  = 3'd3,
        ERR_NACK_DATA = 3'd4
    } t_err;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START1,
        PH_SEND_DEV,
        PH_ACK_DEV,
        PH_SEND_REG,
        PH_ACK_REG,
        PH_SEND_DATA,
        PH_ACK_DATA,
        PH_START2,
        PH_SEND_DEVR,
        PH_ACK_DEVR,
        PH_READ,
        PH_STOP
    } t_phase;

    // Classified request waiting for the sequencer
    typedef struct packed {
        t_kind      kind;
        logic [7:0] dev;
        logic [7:0] regad;
        logic [7:0] data;
        logic       sda;
    } t_item;

    // One result per bus tick
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy;
        logic       done;
        logic       success;
        t_err       err;
        logic [7:0] rd;
    } t_result;

endpackage

### sv/i2cram_front.sv
// Front end: classifies incoming requests and queues them for the sequencer.
`timescale 1ns / 1ps

module i2cram_front
    import i2cram_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               w_acc;
    logic               w_take;
    t_item              w_item;

    // Classify the opcode; the unused code counts as a plain tick
    always_comb begin
        w_item.dev   = i_device_addr;
        w_item.regad = i_reg_addr;
        w_item.data  = i_write_data;
        w_item.sda   = i_sda_in;
        case (i_op)
            OP_WRITE: w_item.kind = KIND_WRITE;
            OP_READ:  w_item.kind = KIND_READ;
            default:  w_item.kind = KIND_TICK;
        endcase
    end

    assign full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_acc   = push && !full;
    assign w_take  = i_take && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = w_acc  ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_take ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = QCNT_W'(r_count + QCNT_W'(w_acc) - QCNT_W'(w_take));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the accepted request
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

### sv/i2cram_seq.sv
// Back end: bus sequencer that turns one queued tick into one result.
`timescale 1ns / 1ps

module i2cram_seq
    import i2cram_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_res_full,
    output logic    o_res_wr,
    output t_result o_res
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_tick, n_tick;
    logic [3:0] r_bit_cnt, n_bit_cnt;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_is_read, n_is_read;
    t_err       r_err, n_err;
    logic       r_nack, n_nack;
    logic       r_sda_level, n_sda_level;

    logic       w_cmd;
    t_phase     e_phase;
    logic [1:0] e_tick;
    logic [3:0] e_bit_cnt;
    logic [7:0] e_shift;
    logic       e_is_read;
    t_err       e_err;
    logic       e_nack;
    logic       w_fail;
    logic [3:0] w_bit_inc;
    logic [7:0] w_dev_rd;
    logic       w_ok;

    assign o_take   = i_valid && !i_res_full;
    assign o_res_wr = o_take;

    // A command in idle starts the transaction on its own tick
    assign w_cmd     = (r_phase == PH_IDLE) && (i_item.kind != KIND_TICK);
    assign e_phase   = w_cmd ? PH_START1 : r_phase;
    assign e_tick    = w_cmd ? 2'd0 : r_tick;
    assign e_bit_cnt = w_cmd ? 4'd0 : r_bit_cnt;
    assign e_shift   = w_cmd ? 8'd0 : r_shift;
    assign e_is_read = w_cmd ? (i_item.kind == KIND_READ) : r_is_read;
    assign e_err     = w_cmd ? ERR_NONE : r_err;
    assign e_nack    = w_cmd ? 1'b0 : r_nack;

    assign w_fail    = ((e_tick == 2'd0) && !i_item.sda) ||
                       ((e_tick == 2'd1) && i_item.sda);
    assign w_bit_inc = 4'(e_bit_cnt + 4'd1);
    assign w_dev_rd  = 8'(n_dev + 8'd1);
    assign w_ok      = (r_err == ERR_NONE);

    // Next state of the sequencer
    always_comb begin
        n_phase     = e_phase;
        n_tick      = e_tick;
        n_bit_cnt   = e_bit_cnt;
        n_shift     = e_shift;
        n_dev       = w_cmd ? i_item.dev   : r_dev;
        n_reg       = w_cmd ? i_item.regad : r_reg;
        n_data      = w_cmd ? i_item.data  : r_data;
        n_is_read   = e_is_read;
        n_err       = e_err;
        n_nack      = e_nack;
        n_sda_level = r_sda_level;
        case (e_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_START1, PH_START2: begin
                if (e_tick == 2'd0) begin
                    n_sda_level = 1'b1;
                    n_tick      = 2'd1;
                end else if (e_tick == 2'd1) begin
                    n_sda_level = 1'b0;
                    n_tick      = 2'd2;
                end else begin
                    n_phase   = (e_phase == PH_START1) ? PH_SEND_DEV : PH_SEND_DEVR;
                    n_tick    = 2'd0;
                    n_bit_cnt = 4'd0;
                    n_shift   = (e_phase == PH_START1) ? n_dev : w_dev_rd;
                end
                // Failed start: skip on a repeated start, stop on a read, drop a write
                if (w_fail) begin
                    if (e_phase == PH_START2) begin
                        n_phase   = PH_SEND_DEVR;
                        n_tick    = 2'd0;
                        n_bit_cnt = 4'd0;
                        n_shift   = w_dev_rd;
                    end else if (e_is_read) begin
                        n_err     = ERR_START;
                        n_phase   = PH_STOP;
                        n_tick    = 2'd0;
                        n_bit_cnt = 4'd0;
                    end else begin
                        n_phase = PH_IDLE;
                        n_tick  = 2'd0;
                    end
                end
            end
            PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_DEVR: begin
                if (e_tick == 2'd0) begin
                    n_tick = 2'd1;
                end else if (e_tick == 2'd1) begin
                    n_sda_level = e_shift[7];
                    n_shift     = {e_shift[6:0], 1'b0};
                    n_tick      = 2'd2;
                end else begin
                    n_tick    = 2'd0;
                    n_bit_cnt = w_bit_inc;
                    if (w_bit_inc >= BITS_PER_BYTE) begin
                        n_bit_cnt = 4'd0;
                        case (e_phase)
                            PH_SEND_DEV:  n_phase = PH_ACK_DEV;
                            PH_SEND_REG:  n_phase = PH_ACK_REG;
                            PH_SEND_DATA: n_phase = PH_ACK_DATA;
                            default:      n_phase = PH_ACK_DEVR;
                        endcase
                    end
                end
            end
            PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
                if (e_tick == 2'd0) begin
                    n_tick = 2'd1;
                end else if (e_tick == 2'd1) begin
                    n_sda_level = 1'b1;
                    n_tick      = 2'd2;
                end else if (e_tick == 2'd2) begin
                    n_nack = i_item.sda;
                    n_tick = 2'd3;
                end else begin
                    n_tick    = 2'd0;
                    n_bit_cnt = 4'd0;
                    case (e_phase)
                        PH_ACK_DEV: begin
                            if (e_nack) begin
                                n_err   = ERR_NACK_ADDR;
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_SEND_REG;
                                n_shift = n_reg;
                            end
                        end
                        PH_ACK_REG: begin
                            if (e_is_read) begin
                                n_phase = PH_START2;
                                n_shift = 8'd0;
                            end else if (e_nack) begin
                                n_err   = ERR_NACK_REG;
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_SEND_DATA;
                                n_shift = n_data;
                            end
                        end
                        PH_ACK_DATA: begin
                            n_err   = e_nack ? ERR_NACK_DATA : ERR_NONE;
                            n_phase = PH_STOP;
                        end
                        default: begin
                            n_phase = PH_READ;
                            n_shift = 8'd0;
                        end
                    endcase
                end
            end
            PH_READ: begin
                if (e_tick == 2'd0) begin
                    n_sda_level = 1'b1;
                    n_tick      = 2'd1;
                end else begin
                    n_shift   = {e_shift[6:0], i_item.sda};
                    n_tick    = 2'd0;
                    n_bit_cnt = w_bit_inc;
                    if (w_bit_inc >= BITS_PER_BYTE) begin
                        n_err     = ERR_NONE;
                        n_phase   = PH_STOP;
                        n_bit_cnt = 4'd0;
                    end
                end
            end
            PH_STOP: begin
                if (e_tick == 2'd0) begin
                    n_tick = 2'd1;
                end else if (e_tick == 2'd1) begin
                    n_sda_level = 1'b0;
                    n_tick      = 2'd2;
                end else if (e_tick == 2'd2) begin
                    n_tick = 2'd3;
                end else begin
                    n_sda_level = 1'b1;
                    n_phase     = PH_IDLE;
                    n_tick      = 2'd0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = 2'd0;
            end
        endcase
    end

    // Line levels and status for this tick
    always_comb begin
        o_res.scl     = 1'b1;
        o_res.sda_out = r_sda_level;
        o_res.busy    = 1'b1;
        o_res.done    = 1'b0;
        o_res.success = 1'b0;
        o_res.err     = ERR_NONE;
        o_res.rd      = 8'd0;
        case (e_phase)
            PH_IDLE: begin
                o_res.busy = 1'b0;
            end
            PH_START1, PH_START2: begin
                o_res.scl     = (e_tick != 2'd2);
                o_res.sda_out = (e_tick == 2'd0);
                if (w_fail && (e_phase == PH_START1) && !e_is_read) begin
                    o_res.done = 1'b1;
                    o_res.err  = ERR_START;
                end
            end
            PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_DEVR: begin
                o_res.scl     = (e_tick == 2'd2);
                o_res.sda_out = (e_tick == 2'd1) ? e_shift[7] : r_sda_level;
            end
            PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
                o_res.scl     = (e_tick == 2'd2);
                o_res.sda_out = (e_tick == 2'd0) ? r_sda_level : 1'b1;
            end
            PH_READ: begin
                o_res.scl     = (e_tick != 2'd0);
                o_res.sda_out = 1'b1;
            end
            PH_STOP: begin
                case (e_tick)
                    2'd0: begin
                        o_res.scl     = 1'b0;
                        o_res.sda_out = r_sda_level;
                    end
                    2'd1: begin
                        o_res.scl     = 1'b0;
                        o_res.sda_out = 1'b0;
                    end
                    2'd2: begin
                        o_res.scl     = 1'b1;
                        o_res.sda_out = 1'b0;
                    end
                    default: begin
                        o_res.scl     = 1'b1;
                        o_res.sda_out = 1'b1;
                        o_res.done    = 1'b1;
                        o_res.success = w_ok;
                        o_res.err     = r_err;
                        o_res.rd      = (r_is_read && w_ok) ? r_shift : 8'd0;
                    end
                endcase
            end
            default: begin
                o_res.busy = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= 2'd0;
            r_bit_cnt   <= 4'd0;
            r_is_read   <= 1'b0;
            r_err       <= ERR_NONE;
            r_nack      <= 1'b0;
            r_sda_level <= 1'b1;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit_cnt   <= n_bit_cnt;
            r_is_read   <= n_is_read;
            r_err       <= n_err;
            r_nack      <= n_nack;
            r_sda_level <= n_sda_level;
        end
    end

    // Shift and latched bytes
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_shift <= n_shift;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_data  <= n_data;
        end
    end

    // A finished transaction is always a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.done) |-> o_res.busy)
        else $error("done reported outside a transaction");

    // Status fields stay clear unless the transaction ends
    a_quiet_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && !o_res.done) |->
            (!o_res.success && (o_res.err == ERR_NONE) && (o_res.rd == 8'd0)))
        else $error("status fields set on a non-final tick");

    // Success and an error code never go together
    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.success) |-> (o_res.err == ERR_NONE))
        else $error("success with an error code");

    // Bit counter stays within one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt < BITS_PER_BYTE)
        else $error("bit counter overran a byte");

endmodule

### sv/i2cram_resq.sv
// Result queue between the sequencer and the output ports.
`timescale 1ns / 1ps

module i2cram_resq
    import i2cram_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    t_result            r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               w_pop;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);
    assign o_res  = r_q[r_rd_ptr];
    assign w_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_wr  ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = QCNT_W'(r_count + QCNT_W'(i_wr) - QCNT_W'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold the written result
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    // The sequencer never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("result written into a full queue");

endmodule

### sv/i2c_register_access_master.sv
// Top level of the I2C register access master.
//
// Usage: every request is one bus tick carrying the sampled SDA level; a
// request with op write or read, given while no transaction runs, starts a
// register write or read on that same tick. Requests enter through push/full
// and every request yields exactly one result (SCL and SDA levels, busy,
// done, success, error code, read byte), taken through empty/pop in order.
// A request is held in the request queue, its result in the result queue
// until popped. Throughput: one request per cycle while results are popped;
// the sequencer handles one tick per clock unless the result queue is full;
// two-entry queues on both sides keep it running while either neighbor pauses.
// Reset (synchronous, active low) empties both queues and returns the
// sequencer to idle with SDA released high.
// When the receiver stops popping, the result queue fills, the sequencer
// halts and the request queue then raises full; nothing is dropped.
`timescale 1ns / 1ps

module i2c_register_access_master
    import i2cram_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_success,
    output logic [2:0] o_error_code,
    output logic [7:0] o_read_data
);

    logic    w_item_valid;
    t_item   w_item;
    logic    w_take;
    logic    w_res_full;
    logic    w_res_wr;
    t_result w_res;
    t_result w_out;

    i2cram_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_device_addr (i_device_addr),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_valid       (w_item_valid),
        .o_item        (w_item),
        .i_take        (w_take)
    );

    i2cram_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_item_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .i_res_full (w_res_full),
        .o_res_wr   (w_res_wr),
        .o_res      (w_res)
    );

    i2cram_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out)
    );

    assign o_scl        = w_out.scl;
    assign o_sda_out    = w_out.sda_out;
    assign o_busy_res   = w_out.busy;
    assign o_done_res   = w_out.done;
    assign o_success    = w_out.success;
    assign o_error_code = w_out.err;
    assign o_read_data  = w_out.rd;

endmodule

### sim/i2cram_bus_checker.sv
// Bus tick predictor and result checker for the I2C register access master.
`timescale 1ns / 1ps

module i2cram_bus_checker
    import i2cram_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic       i_scl,
    input  logic       i_sda_out,
    input  logic       i_busy_res,
    input  logic       i_done_res,
    input  logic       i_success,
    input  logic [2:0] i_error_code,
    input  logic [7:0] i_read_data,
    output int         o_mismatch_count,
    output int         o_pending
);

    // Shadow copy of the bus sequencer
    t_phase     phase;
    logic [1:0] tick_idx;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic [7:0] dev_q;
    logic [7:0] reg_q;
    logic [7:0] data_q;
    logic       rd_mode;
    t_err       err_q;
    logic       nack_q;
    logic       sda_lvl;

    // Bus ticks predicted for accepted requests, oldest first
    t_result expected_ticks[$];
    int      mismatch_count = 0;
    int      pending_count  = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_pending        = pending_count;

    function automatic t_result make_tick(input logic c, d, busy, done, ok,
                                          input t_err e, input logic [7:0] rd);
        t_result r;
        r.scl     = c;
        r.sda_out = d;
        r.busy    = busy;
        r.done    = done;
        r.success = ok;
        r.err     = e;
        r.rd      = rd;
        return r;
    endfunction

    function automatic void enter_phase(input t_phase ph, input logic [7:0] load);
        phase    = ph;
        tick_idx = 2'd0;
        bit_idx  = 4'd0;
        shreg    = load;
    endfunction

    function automatic void enter_stop(input t_err e);
        err_q = e;
        enter_phase(PH_STOP, shreg);
    endfunction

    // Advance the shadow sequencer by one bus tick and return its line levels
    function automatic t_result predict_tick(input logic [1:0] op,
                                             input logic [7:0] dev, regad, data,
                                             input logic sda);
        logic c;
        logic d;
        logic first;
        logic fail;
        logic ok;
        c    = 1'b1;
        d    = 1'b1;
        fail = 1'b0;
        if (phase == PH_IDLE) begin
            // Hold the lines unless a write or read command arrives
            if (op != OP_WRITE && op != OP_READ) begin
                return make_tick(1'b1, sda_lvl, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'd0);
            end
            dev_q   = dev;
            reg_q   = regad;
            data_q  = data;
            rd_mode = (op == OP_READ);
            err_q   = ERR_NONE;
            nack_q  = 1'b0;
            enter_phase(PH_START1, 8'd0);
        end

        case (phase)
            PH_START1, PH_START2: begin
                first = (phase == PH_START1);
                if (tick_idx == 2'd0) begin
                    c = 1'b1; d = 1'b1; sda_lvl = 1'b1;
                    fail = !sda;
                    tick_idx = 2'd1;
                end else if (tick_idx == 2'd1) begin
                    c = 1'b1; d = 1'b0; sda_lvl = 1'b0;
                    fail = sda;
                    tick_idx = 2'd2;
                end else begin
                    c = 1'b0; d = 1'b0;
                    if (first) enter_phase(PH_SEND_DEV, dev_q);
                    else enter_phase(PH_SEND_DEVR, dev_q + 8'd1);
                end
                // A failed repeated start just moves on; a failed first start aborts
                if (fail) begin
                    if (!first) begin
                        enter_phase(PH_SEND_DEVR, dev_q + 8'd1);
                    end else if (rd_mode) begin
                        enter_stop(ERR_START);
                    end else begin
                        phase    = PH_IDLE;
                        tick_idx = 2'd0;
                        return make_tick(c, d, 1'b1, 1'b1, 1'b0, ERR_START, 8'd0);
                    end
                end
            end
            PH_SEND_DEV, PH_SEND_REG, PH_SEND_DATA, PH_SEND_DEVR: begin
                if (tick_idx == 2'd0) begin
                    c = 1'b0; d = sda_lvl;
                    tick_idx = 2'd1;
                end else if (tick_idx == 2'd1) begin
                    sda_lvl = shreg[7];
                    shreg   = {shreg[6:0], 1'b0};
                    c = 1'b0; d = sda_lvl;
                    tick_idx = 2'd2;
                end else begin
                    c = 1'b1; d = sda_lvl;
                    tick_idx = 2'd0;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx >= BITS_PER_BYTE) begin
                        phase   = t_phase'(phase + 1);
                        bit_idx = 4'd0;
                    end
                end
            end
            PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
                if (tick_idx == 2'd0) begin
                    c = 1'b0; d = sda_lvl;
                    tick_idx = 2'd1;
                end else if (tick_idx == 2'd1) begin
                    c = 1'b0; d = 1'b1; sda_lvl = 1'b1;
                    tick_idx = 2'd2;
                end else if (tick_idx == 2'd2) begin
                    c = 1'b1; d = 1'b1;
                    nack_q = sda;
                    tick_idx = 2'd3;
                end else begin
                    c = 1'b0; d = 1'b1;
                    case (phase)
                        PH_ACK_DEV: begin
                            if (nack_q) enter_stop(ERR_NACK_ADDR);
                            else enter_phase(PH_SEND_REG, reg_q);
                        end
                        PH_ACK_REG: begin
                            if (rd_mode) enter_phase(PH_START2, 8'd0);
                            else if (nack_q) enter_stop(ERR_NACK_REG);
                            else enter_phase(PH_SEND_DATA, data_q);
                        end
                        PH_ACK_DATA: begin
                            enter_stop(nack_q ? ERR_NACK_DATA : ERR_NONE);
                        end
                        default: begin
                            enter_phase(PH_READ, 8'd0);
                        end
                    endcase
                end
            end
            PH_READ: begin
                if (tick_idx == 2'd0) begin
                    c = 1'b0; d = 1'b1; sda_lvl = 1'b1;
                    tick_idx = 2'd1;
                end else begin
                    c = 1'b1; d = 1'b1;
                    shreg    = {shreg[6:0], sda};
                    tick_idx = 2'd0;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx >= BITS_PER_BYTE) enter_stop(ERR_NONE);
                end
            end
            PH_STOP: begin
                if (tick_idx == 2'd0) begin
                    c = 1'b0; d = sda_lvl;
                    tick_idx = 2'd1;
                end else if (tick_idx == 2'd1) begin
                    c = 1'b0; d = 1'b0; sda_lvl = 1'b0;
                    tick_idx = 2'd2;
                end else if (tick_idx == 2'd2) begin
                    c = 1'b1; d = 1'b0;
                    tick_idx = 2'd3;
                end else begin
                    ok       = (err_q == ERR_NONE);
                    sda_lvl  = 1'b1;
                    phase    = PH_IDLE;
                    tick_idx = 2'd0;
                    return make_tick(1'b1, 1'b1, 1'b1, 1'b1, ok, err_q,
                                     (rd_mode && ok) ? shreg : 8'd0);
                end
            end
            default: begin
                phase    = PH_IDLE;
                tick_idx = 2'd0;
                return make_tick(1'b1, sda_lvl, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'd0);
            end
        endcase
        return make_tick(c, d, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'd0);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Predict on every accepted request, compare on every accepted result
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            tick_idx = 2'd0;
            bit_idx  = 4'd0;
            shreg    = 8'd0;
            dev_q    = 8'd0;
            reg_q    = 8'd0;
            data_q   = 8'd0;
            rd_mode  = 1'b0;
            err_q    = ERR_NONE;
            nack_q   = 1'b0;
            sda_lvl  = 1'b1;
            expected_ticks.delete();
        end else begin
            if (i_push && !i_full) begin
                expected_ticks.push_back(predict_tick(i_op, i_device_addr, i_reg_addr,
                                                      i_write_data, i_sda_in));
            end
            if (i_pop && !i_empty) begin
                if (expected_ticks.size() == 0) begin
                    $error("result popped with no request pending");
                    mismatch_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("scl", want.scl, i_scl);
                    check_field("sda_out", want.sda_out, i_sda_out);
                    check_field("busy_res", want.busy, i_busy_res);
                    check_field("done_res", want.done, i_done_res);
                    check_field("success", want.success, i_success);
                    check_field("error_code", want.err, i_error_code);
                    check_field("read_data", want.rd, i_read_data);
                end
            end
        end
        pending_count <= expected_ticks.size();
    end

endmodule

### sim/tb_i2c_register_access_master.sv
// Testbench top: bus tick stimulus and verdict for the I2C register access master.
`timescale 1ns / 1ps

module tb_i2c_register_access_master;
    import i2cram_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RESYNC_TICKS = 112;

    // Unused op value, treated as a plain tick
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // How the slave side answers a start condition
    localparam int START_OK   = 0;
    localparam int START_LOW  = 1;
    localparam int START_HIGH = 2;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_op;
    logic [7:0] i_device_addr;
    logic [7:0] i_reg_addr;
    logic [7:0] i_write_data;
    logic       i_sda_in;
    logic       empty;
    logic       pop;
    logic       o_scl;
    logic       o_sda_out;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_success;
    logic [2:0] o_error_code;
    logic [7:0] o_read_data;

    int   mismatch_count;
    int   pending;
    int   cycle_count = 0;
    int   sent_items  = 0;
    logic calm        = 1'b0;

    // SDA level the slave side presents on each tick of one access
    logic tick_plan[$];

    i2c_register_access_master i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_device_addr (i_device_addr),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .empty         (empty),
        .pop           (pop),
        .o_scl         (o_scl),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_success     (o_success),
        .o_error_code  (o_error_code),
        .o_read_data   (o_read_data)
    );

    i2cram_bus_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_op             (i_op),
        .i_device_addr    (i_device_addr),
        .i_reg_addr       (i_reg_addr),
        .i_write_data     (i_write_data),
        .i_sda_in         (i_sda_in),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_scl            (o_scl),
        .i_sda_out        (o_sda_out),
        .i_busy_res       (o_busy_res),
        .i_done_res       (o_done_res),
        .i_success        (o_success),
        .i_error_code     (o_error_code),
        .i_read_data      (o_read_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the result side at random, except in calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 31);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_start(input int fail_pct);
        if ($urandom_range(99) < fail_pct) begin
            return ($urandom_range(1) != 0) ? START_LOW : START_HIGH;
        end
        return START_OK;
    endfunction

    // Push one request, idling at random beforehand
    task automatic send_tick(input logic [1:0] op, input logic [7:0] dev, regad, data,
                             input logic sda);
        while (!calm && $urandom_range(99) < 31) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_device_addr <= dev;
        i_reg_addr    <= regad;
        i_write_data  <= data;
        i_sda_in      <= sda;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_items++;
    endtask

    // Hold off the request side until every result has been popped
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) begin
            send_tick(($urandom_range(1) != 0) ? OP_TICK : OP_UNUSED,
                      8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic plan_noise(input int n);
        repeat (n) tick_plan.push_back(1'($urandom_range(1)));
    endtask

    task automatic plan_start(input int kind);
        if (kind == START_LOW) begin
            tick_plan.push_back(1'b0);
        end else if (kind == START_HIGH) begin
            tick_plan.push_back(1'b1);
            tick_plan.push_back(1'b1);
        end else begin
            tick_plan.push_back(1'b1);
            tick_plan.push_back(1'b0);
            plan_noise(1);
        end
    endtask

    // Acknowledge slot: the level counts on its third tick
    task automatic plan_ack(input logic nack);
        plan_noise(2);
        tick_plan.push_back(nack);
        plan_noise(1);
    endtask

    // Lay out the slave answers of one access tick by tick, then send it
    task automatic run_access(input logic [1:0] op, input logic [7:0] dev, regad, data,
                              rd_byte, input int start_kind, start2_kind,
                              input logic nack_dev, nack_reg, nack_data, broken);
        logic reading;
        reading = (op == OP_READ);
        tick_plan.delete();
        plan_start(start_kind);
        if (start_kind != START_OK) begin
            if (reading) plan_noise(4);
        end else begin
            plan_noise(24);
            plan_ack(nack_dev);
            if (nack_dev) begin
                plan_noise(4);
            end else begin
                plan_noise(24);
                if (reading) begin
                    plan_noise(4);
                    plan_start(start2_kind);
                    plan_noise(28);
                    for (int i = 7; i >= 0; i--) begin
                        plan_noise(1);
                        tick_plan.push_back(rd_byte[i]);
                    end
                    plan_noise(4);
                end else begin
                    plan_ack(nack_reg);
                    if (!nack_reg) begin
                        plan_noise(24);
                        plan_ack(nack_data);
                    end
                    plan_noise(4);
                end
            end
        end
        // Scramble the answers for a broken sequence
        if (broken) begin
            foreach (tick_plan[k]) tick_plan[k] = 1'($urandom_range(1));
        end
        // Carry the command on the first tick, noise on the ignored op after it
        foreach (tick_plan[k]) begin
            if (k == 0) begin
                send_tick(op, dev, regad, data, tick_plan[k]);
            end else begin
                send_tick(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          8'($urandom), tick_plan[k]);
            end
        end
    endtask

    initial begin
        int         access_idx;
        int         random_floor;
        logic [1:0] op_sel;
        logic       broken;
        push          <= 1'b0;
        i_op          <= OP_TICK;
        i_device_addr <= 8'd0;
        i_reg_addr    <= 8'd0;
        i_write_data  <= 8'd0;
        i_sda_in      <= 1'b1;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, unused op, start failures, commands while busy
        send_tick(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_tick(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        run_access(OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'h00, START_LOW, START_OK,
                   1'b0, 1'b0, 1'b0, 1'b0);
        run_access(OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, START_HIGH, START_OK,
                   1'b0, 1'b0, 1'b0, 1'b0);
        run_access(OP_READ, 8'hFF, 8'h00, 8'hFF, 8'h00, START_LOW, START_OK,
                   1'b0, 1'b0, 1'b0, 1'b0);
        run_access(OP_READ, 8'h00, 8'hFF, 8'h00, 8'hFF, START_HIGH, START_OK,
                   1'b0, 1'b0, 1'b0, 1'b0);
        idle_ticks(2);
        drain();

        // Random: mostly well-formed accesses with random content and faults
        random_floor = sent_items;
        access_idx   = 0;
        while (sent_items < random_floor + RANDOM_ITEMS) begin
            calm <= (access_idx >= 6 && access_idx < 10);
            if (access_idx % 5 == 4) drain();
            op_sel = ($urandom_range(1) != 0) ? OP_READ : OP_WRITE;
            broken = ($urandom_range(9) == 0);
            run_access(op_sel, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       pick_start(15), pick_start(30),
                       1'($urandom_range(99) < 20), 1'($urandom_range(99) < 20),
                       1'($urandom_range(99) < 20), broken);
            // Let a scrambled access run out before the next command
            if (broken) idle_ticks(RESYNC_TICKS);
            else idle_ticks($urandom_range(3));
            access_idx++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
